// File: rtl/core/adsr_envelope_generator_defines.svh
// Assertion macros shared by the envelope generator checker.
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

// Both macros expect signals named clk and rst_n in the scope where they are used.
`define ADSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/adsr_pkg.sv
// Shared types, codes and constants of the envelope generator.
package adsr_pkg;

  localparam int TIME_BITS_DEF   = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int DUR_W           = 24;
  localparam int LVL_W           = 16;
  localparam int NUM_W           = DUR_W + LVL_W;
  localparam int ACT_W           = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;

  typedef logic [ACT_W-1:0]     action_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DUR_W-1:0]     dur_t;
  typedef logic [LVL_W-1:0]     lvl_t;

  localparam action_t ACT_SAMPLE = 2'd0;
  localparam action_t ACT_START  = 2'd1;
  localparam action_t ACT_STOP   = 2'd2;

  localparam cfg_idx_t REG_ATTACK  = 3'd0;
  localparam cfg_idx_t REG_DECAY   = 3'd1;
  localparam cfg_idx_t REG_RELEASE = 3'd2;
  localparam cfg_idx_t REG_PEAK    = 3'd3;
  localparam cfg_idx_t REG_HOLD    = 3'd4;

  localparam dur_t ATTACK_RST  = 24'd4800;
  localparam dur_t DECAY_RST   = 24'd4800;
  localparam dur_t RELEASE_RST = 24'd4800;
  localparam lvl_t PEAK_RST    = 16'd32768;
  localparam lvl_t HOLD_RST    = 16'd26214;

  localparam lvl_t LEVEL_ONE   = 16'd32768;
  localparam lvl_t LEVEL_FLOOR = 16'd3;

endpackage

// File: rtl/core/adsr_in_if.sv
// Input channel of the envelope generator: action, time stamp and wave sample.
interface adsr_in_if #(
  parameter int TIME_BITS   = adsr_pkg::TIME_BITS_DEF,
  parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF
);
  import adsr_pkg::*;

  logic                          valid;
  logic                          ready;
  action_t                       action;
  logic [TIME_BITS-1:0]          now;
  logic signed [SAMPLE_BITS-1:0] wave_sample;

  modport source (output valid, action, now, wave_sample, input ready);
  modport sink (input valid, action, now, wave_sample, output ready);
endinterface

// File: rtl/core/adsr_out_if.sv
// Result channel of the envelope generator: shaped sample and applied level.
interface adsr_out_if #(
  parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF
);
  import adsr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] shaped_sample;
  lvl_t                          level;

  modport source (output valid, shaped_sample, level, input ready);
  modport sink (input valid, shaped_sample, level, output ready);
endinterface

// File: rtl/core/adsr_envelope_generator.sv
// Timestamped ADSR envelope generator with a bit-serial datapath.
//
// Channel   Direction  Handshake      Word
// in_ch     in         valid/ready    action, now, wave_sample
// out_ch    out        valid/ready    shaped_sample, level
// cfg_*     in         cfg_we         cfg_index, cfg_wdata
//
// A start or stop word leaves the input ready. A sample word holds the input off while it
// runs its steps in order: setup in S_SEL and, past the attack, S_DEC, then the serial
// multiply-accumulate, restoring divider, clamp, serial output multiply and hand-off.
// Sustain and a finished release skip the multiply-accumulate and the divider.
// Synchronous reset loads the register defaults and clears the gate and time marks.
// A finished word waits in the output register; the last step holds while it is full.
module adsr_envelope_generator #(
  parameter int TIME_BITS   = adsr_pkg::TIME_BITS_DEF,
  parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  adsr_in_if.sink                          in_ch,
  adsr_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import adsr_pkg::*;

  localparam int DW    = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
  localparam int PW    = SAMPLE_BITS + LVL_W;
  localparam int CNT_W = $clog2(DUR_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEL   = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  dur_t                          attack_r, decay_r, release_r;
  lvl_t                          peak_r, hold_r;
  logic                          gate_r, gate_nxt;
  logic [TIME_BITS-1:0]          on_time_r, on_time_nxt;
  logic [TIME_BITS-1:0]          off_time_r, off_time_nxt;
  logic [DW-1:0]                 diff_r, diff_nxt;
  logic signed [SAMPLE_BITS-1:0] wave_r, wave_nxt;
  dur_t                          x_r, x_nxt, y_r, y_nxt, div_r, div_nxt;
  lvl_t                          wx_r, wx_nxt, wy_r, wy_nxt;
  logic [NUM_W-1:0]              acc_r, acc_nxt;
  lvl_t                          lvl_r, lvl_nxt, sh_r, sh_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] shaped_r, shaped_nxt;
  lvl_t                          level_r, level_nxt;

  logic [TIME_BITS-1:0] elapsed;
  dur_t                 a_eff, d_eff, r_eff;
  logic [DUR_W:0]       div_t_w, div_sub;
  logic                 q_bit;
  logic [PW-1:0]        wave_ext;
  lvl_t                 lvl_clamped;

  function automatic lvl_t clamp_level(input lvl_t q);
    lvl_t res;
    res = q;
    if (q > LEVEL_ONE) begin
      res = LEVEL_ONE;
    end else if (q <= LEVEL_FLOOR) begin
      res = '0;
    end
    return res;
  endfunction

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.shaped_sample = shaped_r;
  assign out_ch.level         = level_r;

  assign elapsed  = in_ch.now - (gate_r ? on_time_r : off_time_r);
  assign a_eff    = (attack_r == '0) ? DUR_W'(1) : attack_r;
  assign d_eff    = (decay_r == '0) ? DUR_W'(1) : decay_r;
  assign r_eff    = (release_r == '0) ? DUR_W'(1) : release_r;
  assign div_t_w  = {acc_r[NUM_W-1:LVL_W], acc_r[LVL_W-1]};
  assign div_sub  = div_t_w - {1'b0, div_r};
  assign q_bit    = (div_t_w >= {1'b0, div_r});
  assign wave_ext = {{LVL_W{wave_r[SAMPLE_BITS-1]}}, wave_r};
  assign lvl_clamped = clamp_level(acc_r[LVL_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    gate_nxt      = gate_r;
    on_time_nxt   = on_time_r;
    off_time_nxt  = off_time_r;
    diff_nxt      = diff_r;
    wave_nxt      = wave_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    div_nxt       = div_r;
    acc_nxt       = acc_r;
    lvl_nxt       = lvl_r;
    sh_nxt        = sh_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    shaped_nxt    = shaped_r;
    level_nxt     = level_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.action)
            ACT_START: begin
              if (!gate_r) begin
                gate_nxt    = 1'b1;
                on_time_nxt = in_ch.now;
              end
            end
            ACT_STOP: begin
              if (gate_r) begin
                gate_nxt     = 1'b0;
                off_time_nxt = in_ch.now;
              end
            end
            ACT_SAMPLE: begin
              diff_nxt  = DW'(elapsed);
              wave_nxt  = in_ch.wave_sample;
              state_nxt = S_SEL;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEL: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        y_nxt   = '0;
        wy_nxt  = '0;
        if (gate_r) begin
          if (diff_r <= DW'(a_eff)) begin
            x_nxt     = diff_r[DUR_W-1:0];
            wx_nxt    = peak_r;
            div_nxt   = a_eff;
            state_nxt = S_MAC;
          end else begin
            diff_nxt  = diff_r - DW'(a_eff);
            state_nxt = S_DEC;
          end
        end else begin
          if (diff_r >= DW'(r_eff)) begin
            state_nxt = S_CLAMP;
          end else begin
            x_nxt     = r_eff - diff_r[DUR_W-1:0];
            wx_nxt    = hold_r;
            div_nxt   = r_eff;
            state_nxt = S_MAC;
          end
        end
      end
      S_DEC: begin
        if (diff_r <= DW'(d_eff)) begin
          x_nxt     = d_eff - diff_r[DUR_W-1:0];
          y_nxt     = diff_r[DUR_W-1:0];
          wx_nxt    = peak_r;
          wy_nxt    = hold_r;
          div_nxt   = d_eff;
          state_nxt = S_MAC;
        end else begin
          acc_nxt   = NUM_W'(hold_r);
          state_nxt = S_CLAMP;
        end
      end
      S_MAC: begin
        acc_nxt = {acc_r[NUM_W-2:0], 1'b0}
                + (x_r[DUR_W-1] ? NUM_W'(wx_r) : '0)
                + (y_r[DUR_W-1] ? NUM_W'(wy_r) : '0);
        x_nxt   = {x_r[DUR_W-2:0], 1'b0};
        y_nxt   = {y_r[DUR_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DUR_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        acc_nxt = {(q_bit ? div_sub[DUR_W-1:0] : div_t_w[DUR_W-1:0]),
                   acc_r[LVL_W-2:0], q_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LVL_W - 1)) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        lvl_nxt   = lvl_clamped;
        sh_nxt    = lvl_clamped;
        prod_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        prod_nxt = {prod_r[PW-2:0], 1'b0} + (sh_r[LVL_W-1] ? wave_ext : '0);
        sh_nxt   = {sh_r[LVL_W-2:0], 1'b0};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LVL_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          shaped_nxt    = prod_r[PW-2:LVL_W-1];
          level_nxt     = lvl_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gate_r      <= 1'b0;
      on_time_r   <= '0;
      off_time_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gate_r      <= gate_nxt;
      on_time_r   <= on_time_nxt;
      off_time_r  <= off_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RST;
      decay_r   <= DECAY_RST;
      release_r <= RELEASE_RST;
      peak_r    <= PEAK_RST;
      hold_r    <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_r  <= cfg_wdata[DUR_W-1:0];
        REG_DECAY:   decay_r   <= cfg_wdata[DUR_W-1:0];
        REG_RELEASE: release_r <= cfg_wdata[DUR_W-1:0];
        REG_PEAK:    peak_r    <= cfg_wdata[LVL_W-1:0];
        REG_HOLD:    hold_r    <= cfg_wdata[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    diff_r   <= diff_nxt;
    wave_r   <= wave_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    wx_r     <= wx_nxt;
    wy_r     <= wy_nxt;
    div_r    <= div_nxt;
    acc_r    <= acc_nxt;
    lvl_r    <= lvl_nxt;
    sh_r     <= sh_nxt;
    prod_r   <= prod_nxt;
    shaped_r <= shaped_nxt;
    level_r  <= level_nxt;
  end

endmodule

// File: rtl/core/adsr_checker.sv
// Port-level assertion checker for the envelope generator and its bind statement.
`include "adsr_envelope_generator_defines.svh"

module adsr_checker #(
  parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [adsr_pkg::ACT_W-1:0]     in_action,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_BITS-1:0]  out_shaped_sample,
  input logic [adsr_pkg::LVL_W-1:0]     out_level
);
  import adsr_pkg::*;

  `ADSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_shaped_sample) && $stable(out_level), "Result word changed while stalled.")
  `ADSR_ASSERT_NOW(a_level_range, out_valid, (out_level <= LEVEL_ONE) && (out_level == '0 || out_level > LEVEL_FLOOR), "Level outside its clamped range.")
  `ADSR_ASSERT_NOW(a_zero_level_mute, out_valid && out_level == '0, out_shaped_sample == '0, "Nonzero sample with zero level.")
  `ADSR_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && in_action == ACT_SAMPLE, !in_ready, "Input ready right after a sample word.")
  `ADSR_ASSERT_NEXT(a_ctrl_ready, in_valid && in_ready && in_action != ACT_SAMPLE, in_ready, "Input not ready after a control word.")

endmodule

bind adsr_envelope_generator adsr_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_adsr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_action         (in_ch.action),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_shaped_sample (out_ch.shaped_sample),
  .out_level         (out_ch.level)
);
